### rtl/thcj_pkg.sv
// thcj_pkg: shared constants, voltage table, types and helpers for the
// thermocouple cold-junction linearizer. No dependencies.
`timescale 1ns / 1ps

package thcj_pkg;

  localparam int ROM_POINTS    = 40;
  localparam int TABLE_ENTRIES = 40;
  localparam int N_USE = (TABLE_ENTRIES < 2) ? 2 :
                         ((TABLE_ENTRIES > ROM_POINTS) ? ROM_POINTS : TABLE_ENTRIES);

  localparam int STEP_Q8    = 2560;
  localparam int FIRST_T_Q8 = -23040;
  localparam int OUT_LOW    = -40000;
  localparam int OUT_HIGH   = 80000;

  // junction temperature: floor(x / 10) by reciprocal, x made non-negative
  localparam int          CJ_OFS    = 1600000;
  localparam int          CJ_BIAS_Q = 160000;
  localparam logic [22:0] M10       = 23'd6710887;

  // floor(y / 5) by reciprocal, y made non-negative
  localparam int          DIV5_OFS  = 655360;
  localparam int          DIV5_BIAS = 131072;
  localparam logic [20:0] M5        = 21'd1677722;

  localparam int QUO_W = 22;
  localparam int NUM_W = 31;
  localparam int DEN_W = 11;

  typedef logic signed [18:0] temp_t;
  typedef logic signed [19:0] volt_t;
  typedef logic signed [15:0] rom_t;
  typedef logic [9:0]         dv_t;

  localparam rom_t VOLT_ROM [ROM_POINTS] = '{
    -16'sd3321, -16'sd2990, -16'sd2649, -16'sd2297, -16'sd1934,
    -16'sd1564, -16'sd1184, -16'sd797,  -16'sd401,  16'sd0,
    16'sd407,   16'sd817,   16'sd1232,  16'sd1651,  16'sd2072,
    16'sd2494,  16'sd2919,  16'sd3345,  16'sd3770,  16'sd4194,
    16'sd4617,  16'sd5038,  16'sd5456,  16'sd5873,  16'sd6285,
    16'sd6697,  16'sd7108,  16'sd7516,  16'sd7925,  16'sd8333,
    16'sd8744,  16'sd9155,  16'sd9567,  16'sd9981,  16'sd10397,
    16'sd10814, 16'sd11234, 16'sd11655, 16'sd12078, 16'sd12502
  };

  typedef enum logic {
    CFG_BIAS   = 1'b0,
    CFG_OFFSET = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    temp_t cj_t;
    logic  open;
    logic  cj_above;
    logic  sum_above;
  } side_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             neg;
    temp_t            base;
    side_t            side;
  } div_req_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic             neg;
    temp_t            base;
    side_t            side;
  } div_rsp_t;

  function automatic temp_t temp_at(input int i);
    return temp_t'(FIRST_T_Q8 + i * STEP_Q8);
  endfunction

  function automatic dv_t rom_dv(input int i);
    return dv_t'(VOLT_ROM[i+1] - VOLT_ROM[i]);
  endfunction

  function automatic logic signed [17:0] sat_out(input logic signed [23:0] x);
    logic signed [23:0] y;
    y = x;
    if (y < 24'(OUT_LOW)) y = 24'(OUT_LOW);
    if (y > 24'(OUT_HIGH)) y = 24'(OUT_HIGH);
    return y[17:0];
  endfunction

endpackage

### rtl/thermocouple_cold_junction_linearizer_unit.sv
// thermocouple_cold_junction_linearizer_unit: top level with configuration
// registers and output register. Depends on thcj_pkg, thcj_comp, thcj_inv.
//
// Usage: each request on the slave stream carries a cold-junction code and
// a thermocouple code; one result per request leaves on the master stream
// with hot and cold junction temperatures in 1/256 degree C and three flags.
// The bias code and final offset are written through the cfg port while the
// block is idle; reset loads 8000 and -1024 and empties the pipeline.
// The pipeline has 8 compensation stages, 2 search/set-up stages, a
// 22-stage divider (one quotient bit per stage) and the output register.
// A new request can enter every cycle. When the receiver stalls with a
// result waiting, the whole pipeline holds and s_axis_tready_o falls;
// nothing is lost or repeated.
`timescale 1ns / 1ps

module thermocouple_cold_junction_linearizer_unit import thcj_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // cold_junction_code [15:0], couple_code [31:16]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // temperature_q8 [17:0], junction_temp_q8 [35:18], zero pad [39:36]
  output logic [39:0] m_axis_tdata_o,
  // open_couple [0], junction_above_table [1], sum_above_table [2]
  output logic [2:0]  m_axis_tuser_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0]        bias_q;
  logic signed [15:0] offset_q;
  logic               out_vld_q;
  logic signed [17:0] temp_q;
  logic signed [17:0] junc_q;
  logic [2:0]         flags_q;

  logic               ce;
  logic               comp_vld;
  volt_t              comp_sum;
  side_t              comp_side;
  logic               inv_vld;
  div_rsp_t           inv_rsp;
  logic signed [22:0] q_w;
  logic signed [23:0] hot_w;

  assign ce = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q   <= 16'd8000;
      offset_q <= -16'sd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BIAS:   bias_q   <= cfg_wdata_i;
        CFG_OFFSET: offset_q <= $signed(cfg_wdata_i);
        default:    ;
      endcase
    end
  end

  thcj_comp u_comp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (s_axis_tvalid_i),
    .cj_i    ($signed(s_axis_tdata_i[15:0])),
    .tc_i    ($signed(s_axis_tdata_i[31:16])),
    .bias_i  (bias_q),
    .valid_o (comp_vld),
    .sum_v_o (comp_sum),
    .side_o  (comp_side)
  );

  thcj_inv u_inv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce),
    .valid_i (comp_vld),
    .sum_v_i (comp_sum),
    .side_i  (comp_side),
    .valid_o (inv_vld),
    .rsp_o   (inv_rsp)
  );

  always_comb begin
    q_w   = inv_rsp.neg ? -$signed({1'b0, inv_rsp.quo}) : $signed({1'b0, inv_rsp.quo});
    hot_w = 24'(inv_rsp.base) + 24'(q_w) + 24'(offset_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ce) begin
      out_vld_q <= inv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      temp_q  <= sat_out(hot_w);
      junc_q  <= sat_out(24'(inv_rsp.side.cj_t));
      flags_q <= {inv_rsp.side.sum_above, inv_rsp.side.cj_above, inv_rsp.side.open};
    end
  end

  assign s_axis_tready_o = ce;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, junc_q, temp_q};
  assign m_axis_tuser_o  = flags_q;

  // a held result blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("request accepted while result stalled");

  // junction above the table means a junction temperature beyond the last point
  a_junction_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |->
      $signed(m_axis_tdata_o[35:18]) > 18'(temp_at(N_USE - 1)))
    else $error("junction flag without matching temperature");

endmodule

### rtl/thcj_comp.sv
// thcj_comp: junction temperature and compensation voltage pipeline, eight
// stages, summed with the thermocouple voltage. Depends on thcj_pkg.
`timescale 1ns / 1ps

module thcj_comp import thcj_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ce_i,
  input  logic               valid_i,
  input  logic signed [15:0] cj_i,
  input  logic signed [15:0] tc_i,
  input  logic [15:0]        bias_i,
  output logic               valid_o,
  output volt_t              sum_v_o,
  output side_t              side_o
);

  logic [7:0]         vld_q;
  logic signed [15:0] tc_q [7];
  logic               open_q [8];
  temp_t              cjt_q [6];
  logic               ab_q [5];
  rom_t               rom_q [4];

  logic [21:0]        s1_x_q;
  logic [44:0]        s2_p_q;
  temp_t              s4_e_q;
  dv_t                s4_dv_q;
  logic signed [28:0] s5_p_q;
  logic [19:0]        s6_ny_q;
  logic [40:0]        s7_p_q;
  volt_t              s8_sum_q;

  logic signed [17:0] d_w;
  logic signed [23:0] x_w;
  temp_t              t_w;
  logic               seg_above;
  temp_t              seg_base;
  rom_t               seg_rom;
  dv_t                seg_dv;
  logic signed [28:0] a_w;
  logic signed [28:0] ny_w;
  temp_t              q_w;
  volt_t              comp_w;

  always_comb begin
    d_w = {{2{cj_i[15]}}, cj_i} - {2'b00, bias_i};
    x_w = (24'(d_w) <<< 4) + 24'sd5 + 24'(CJ_OFS);
    t_w = $signed({1'b0, s2_p_q[43:26]}) - temp_t'(CJ_BIAS_Q);
  end

  always_comb begin
    seg_above = 1'b1;
    seg_base  = temp_at(0);
    seg_rom   = VOLT_ROM[0];
    seg_dv    = rom_dv(0);
    for (int i = N_USE - 2; i >= 0; i--) begin
      if (cjt_q[0] <= temp_at(i + 1)) begin
        seg_above = 1'b0;
        seg_base  = temp_at(i);
        seg_rom   = VOLT_ROM[i];
        seg_dv    = rom_dv(i);
      end
    end
  end

  always_comb begin
    a_w    = s5_p_q + 29'sd1280;
    ny_w   = (a_w >>> 9) + 29'(DIV5_OFS);
    q_w    = $signed({1'b0, s7_p_q[40:23]}) - temp_t'(DIV5_BIAS);
    comp_w = ab_q[3] ? '0 : (volt_t'(rom_q[3]) + volt_t'(q_w));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      s1_x_q    <= x_w[21:0];
      tc_q[0]   <= tc_i;
      open_q[0] <= (tc_i == 16'sh7FFF);
      for (int k = 1; k < 7; k++) begin
        tc_q[k] <= tc_q[k-1];
      end
      for (int k = 1; k < 8; k++) begin
        open_q[k] <= open_q[k-1];
      end
      s2_p_q   <= 45'(s1_x_q) * 45'(M10);
      cjt_q[0] <= t_w;
      for (int k = 1; k < 6; k++) begin
        cjt_q[k] <= cjt_q[k-1];
      end
      s4_e_q   <= cjt_q[0] - seg_base;
      s4_dv_q  <= seg_dv;
      ab_q[0]  <= seg_above;
      rom_q[0] <= seg_rom;
      for (int k = 1; k < 5; k++) begin
        ab_q[k] <= ab_q[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        rom_q[k] <= rom_q[k-1];
      end
      s5_p_q   <= 29'(s4_e_q) * $signed({1'b0, s4_dv_q});
      s6_ny_q  <= ny_w[19:0];
      s7_p_q   <= 41'(s6_ny_q) * 41'(M5);
      s8_sum_q <= comp_w + (volt_t'(tc_q[6]) <<< 3);
    end
  end

  always_comb begin
    valid_o          = vld_q[7];
    sum_v_o          = s8_sum_q;
    side_o.cj_t      = cjt_q[5];
    side_o.open      = open_q[7];
    side_o.cj_above  = ab_q[4];
    side_o.sum_above = 1'b0;
  end

endmodule

### rtl/thcj_div.sv
// thcj_div: pipelined restoring divider, one quotient bit per stage, with
// the request sideband carried alongside. Depends on thcj_pkg.
`timescale 1ns / 1ps

module thcj_div import thcj_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     ce_i,
  input  logic     valid_i,
  input  div_req_t req_i,
  output logic     valid_o,
  output div_rsp_t rsp_o
);

  logic [QUO_W-1:0] vld_q;
  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [NUM_W-1:0] num_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic             neg_q [QUO_W];
  temp_t            base_q [QUO_W];
  side_t            side_q [QUO_W];

  logic [DEN_W-1:0] rin [QUO_W];
  logic [NUM_W-1:0] nin [QUO_W];
  logic [QUO_W-1:0] qin [QUO_W];
  logic [DEN_W-1:0] dn [QUO_W];
  logic [DEN_W:0]   trial [QUO_W];
  logic [DEN_W-1:0] rem_d [QUO_W];
  logic [QUO_W-1:0] quo_d [QUO_W];

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        rin[k] = DEN_W'(req_i.num[NUM_W-1:QUO_W]);
        nin[k] = req_i.num;
        qin[k] = '0;
        dn[k]  = req_i.den;
      end else begin
        rin[k] = rem_q[k-1];
        nin[k] = num_q[k-1];
        qin[k] = quo_q[k-1];
        dn[k]  = den_q[k-1];
      end
      trial[k] = {rin[k], nin[k][QUO_W-1-k]};
      if (trial[k] >= {1'b0, dn[k]}) begin
        rem_d[k] = DEN_W'(trial[k] - {1'b0, dn[k]});
        quo_d[k] = qin[k] | (QUO_W'(1) << (QUO_W - 1 - k));
      end else begin
        rem_d[k] = DEN_W'(trial[k]);
        quo_d[k] = qin[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce_i) begin
      vld_q <= {vld_q[QUO_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k] <= rem_d[k];
        num_q[k] <= nin[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= dn[k];
      end
      neg_q[0]  <= req_i.neg;
      base_q[0] <= req_i.base;
      side_q[0] <= req_i.side;
      for (int k = 1; k < QUO_W; k++) begin
        neg_q[k]  <= neg_q[k-1];
        base_q[k] <= base_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_comb begin
    valid_o    = vld_q[QUO_W-1];
    rsp_o.quo  = quo_q[QUO_W-1];
    rsp_o.neg  = neg_q[QUO_W-1];
    rsp_o.base = base_q[QUO_W-1];
    rsp_o.side = side_q[QUO_W-1];
  end

endmodule

### rtl/thcj_inv.sv
// thcj_inv: voltage-to-temperature conversion: segment search, dividend
// set-up and the pipelined divider. Depends on thcj_pkg and thcj_div.
`timescale 1ns / 1ps

module thcj_inv import thcj_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     ce_i,
  input  logic     valid_i,
  input  volt_t    sum_v_i,
  input  side_t    side_i,
  output logic     valid_o,
  output div_rsp_t rsp_o
);

  logic               s9_vld_q;
  logic signed [20:0] s9_e_q;
  dv_t                s9_dv_q;
  temp_t              s9_base_q;
  side_t              s9_side_q;
  logic               s10_vld_q;
  div_req_t           s10_req_q;

  logic               seg_above;
  temp_t              seg_base;
  rom_t               seg_rom;
  dv_t                seg_dv;
  side_t              side_w;
  logic signed [32:0] x_w;
  logic signed [32:0] xa_w;
  logic [DEN_W-1:0]   den_w;
  div_req_t           req_w;

  always_comb begin
    seg_above = 1'b1;
    seg_base  = temp_at(0);
    seg_rom   = VOLT_ROM[0];
    seg_dv    = rom_dv(0);
    for (int i = N_USE - 2; i >= 0; i--) begin
      if (sum_v_i <= volt_t'(VOLT_ROM[i+1])) begin
        seg_above = 1'b0;
        seg_base  = temp_at(i);
        seg_rom   = VOLT_ROM[i];
        seg_dv    = rom_dv(i);
      end
    end
    side_w           = side_i;
    side_w.sum_above = seg_above;
  end

  always_comb begin
    den_w = {1'b0, s9_dv_q} << 1;
    x_w   = 33'(s9_e_q) * 33'sd5120 + $signed({23'd0, s9_dv_q});
    if (x_w < 0) begin
      xa_w = -x_w + $signed({22'd0, den_w}) - 33'sd1;
    end else begin
      xa_w = x_w;
    end
    req_w.num  = s9_side_q.sum_above ? '0 : xa_w[NUM_W-1:0];
    req_w.den  = den_w;
    req_w.neg  = !s9_side_q.sum_above && (x_w < 0);
    req_w.base = s9_side_q.sum_above ? '0 : s9_base_q;
    req_w.side = s9_side_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
    end else if (ce_i) begin
      s9_vld_q  <= valid_i;
      s10_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      s9_e_q    <= 21'(sum_v_i) - 21'(seg_rom);
      s9_dv_q   <= seg_dv;
      s9_base_q <= seg_base;
      s9_side_q <= side_w;
      s10_req_q <= req_w;
    end
  end

  thcj_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ce_i    (ce_i),
    .valid_i (s10_vld_q),
    .req_i   (s10_req_q),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

endmodule
